@@ sv/ltg_pkg.sv @@
package ltg_pkg;

   localparam int KIND_W      = 2;
   localparam int ADDR_W      = 17;
   localparam int VALUE_W     = 16;
   localparam int X_W         = 9;
   localparam int Y_W         = 8;
   localparam int COLOR_W     = 16;
   localparam int TRIG_W      = 16;
   localparam int YAW_W       = 17;
   localparam int GAIN_W      = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam int DELTA_W     = 12;
   localparam int PROD_W      = 28;
   localparam int SUM_W       = 29;
   localparam int LOC_W       = 14;
   localparam int FRAC_BITS   = 15;
   localparam int U_LSB       = 7;

   localparam int CH_W        = 8;
   localparam int CH_MAX      = 255;
   localparam int GLOW_STEP   = 40;
   localparam int GLOW_RED_MUL   = 7;
   localparam int GLOW_RED_SHIFT = 3;
   localparam int GAIN_SHIFT  = 8;
   localparam int SCALED_W    = CH_W + GAIN_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_LENS   = 2'd0,
      KIND_TEXEL  = 2'd1,
      KIND_RENDER = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_COS = 3'd0,
      CSR_ROT_SIN = 3'd1,
      CSR_YAW     = 3'd2,
      CSR_GAIN    = 3'd3,
      CSR_SHADOW  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic [KIND_W-1:0]  kind;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] value;
      logic [X_W-1:0]     x;
      logic [Y_W-1:0]     y;
   } item_type;

   typedef struct packed {
      logic           valid;
      logic           black;
      logic [2:0]     near;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
   } shade_ctl_type;

endpackage

@@ sv/ltg_req_if.sv @@
interface ltg_req_if;
   import ltg_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [ADDR_W-1:0]  load_address;
   logic [VALUE_W-1:0] load_value;
   logic [X_W-1:0]     pixel_x;
   logic [Y_W-1:0]     pixel_y;

   modport source (output valid, kind, load_address, load_value, pixel_x, pixel_y,
                   input ready);
   modport sink (input valid, kind, load_address, load_value, pixel_x, pixel_y,
                 output ready);

endinterface

@@ sv/ltg_rsp_if.sv @@
interface ltg_rsp_if;
   import ltg_pkg::*;

   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;
   logic [X_W-1:0]     out_x;
   logic [Y_W-1:0]     out_y;

   modport source (output valid, pixel_color, out_x, out_y, input ready);
   modport sink (input valid, pixel_color, out_x, out_y, output ready);

endinterface

@@ sv/ltg_shade.sv @@
module ltg_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  ltg_pkg::shade_ctl_type        ctl_in,
   input  logic [15:0]                   c0,
   input  logic [15:0]                   c1,
   input  logic [7:0]                    fr,
   input  logic [ltg_pkg::GAIN_W-1:0]    gain,
   output ltg_pkg::shade_ctl_type        ctl_out,
   output logic [ltg_pkg::SCALED_W-1:0]  red_out,
   output logic [ltg_pkg::SCALED_W-1:0]  green_out,
   output logic [ltg_pkg::SCALED_W-1:0]  blue_out
);
   import ltg_pkg::*;

   localparam int PRD_W = 18;

   function automatic logic [CH_W-1:0] exp5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   function automatic logic [CH_W-1:0] exp6(input logic [5:0] c);
      return {c, c[5:4]};
   endfunction

   function automatic logic signed [PRD_W-1:0] dprod(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b,
                                                    input logic [7:0] f);
      logic signed [CH_W:0] d;
      logic signed [PRD_W-1:0] p;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, f});
      return p;
   endfunction

   // lerp toward zero, add glow, clamp, scale by gain
   function automatic logic [SCALED_W-1:0] blend(input logic [CH_W-1:0] base,
                                                 input logic signed [PRD_W-1:0] p,
                                                 input logic [CH_W-1:0] glow,
                                                 input logic [GAIN_W-1:0] g);
      logic signed [PRD_W-1:0] adj;
      logic signed [PRD_W-1:0] sum;
      logic [CH_W-1:0] cl;
      adj = p + (p[PRD_W-1] ? PRD_W'(CH_MAX) : PRD_W'(0));
      sum = (adj >>> 8) + $signed(PRD_W'(base)) + $signed(PRD_W'(glow));
      if (sum > $signed(PRD_W'(CH_MAX))) begin
         cl = CH_W'(CH_MAX);
      end else begin
         cl = sum[CH_W-1:0];
      end
      return SCALED_W'(cl) * SCALED_W'(g);
   endfunction

   shade_ctl_type           ctl_a_ff;
   logic [CH_W-1:0]         r0_ff, g0_ff, b0_ff;
   logic signed [PRD_W-1:0] pr_ff, pg_ff, pb_ff;
   shade_ctl_type           ctl_b_ff;
   logic [SCALED_W-1:0]     r_ff, g_ff, b_ff;

   logic [CH_W-1:0] r0_in, g0_in, b0_in;
   logic [CH_W-1:0] glow_in, glow_red_in;

   assign r0_in = exp5(c0[15:11]);
   assign g0_in = exp6(c0[10:5]);
   assign b0_in = exp5(c0[4:0]);
   assign glow_in     = CH_W'(GLOW_STEP * 32'(ctl_a_ff.near));
   assign glow_red_in = CH_W'((GLOW_RED_MUL * 32'(glow_in)) >> GLOW_RED_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff <= r0_in;
         g0_ff <= g0_in;
         b0_ff <= b0_in;
         pr_ff <= dprod(r0_in, exp5(c1[15:11]), fr);
         pg_ff <= dprod(g0_in, exp6(c1[10:5]), fr);
         pb_ff <= dprod(b0_in, exp5(c1[4:0]), fr);
         r_ff  <= blend(r0_ff, pr_ff, glow_red_in, gain);
         g_ff  <= blend(g0_ff, pg_ff, glow_in, gain);
         b_ff  <= blend(b0_ff, pb_ff, glow_in, gain);
      end
   end

   assign ctl_out   = ctl_b_ff;
   assign red_out   = r_ff;
   assign green_out = g_ff;
   assign blue_out  = b_ff;

endmodule

@@ sv/lens_table_texture_gather.sv @@
// lens table texture gather
// req carries words of three kinds: a lens table load, a panorama texel load and
// a render request for one screen pixel; loads give no rsp word, a render gives
// exactly one rsp word with the packed 565 color and the pixel's coordinates.
// csr_write_enable writes csr_write_data to the register at csr_index; write
// registers only while no render is in flight.
// throughput: one word per cycle unless req.ready drops; loads and renders mix freely.
// a render's rsp word passes the item stages, ltg_shade and the output register.
// the lens table sits in three copies, two with two read ports, one with one,
// so center and four neighbors read in the same cycle; the panorama has one
// memory with two read ports for the two texels. loads write the memories in
// the pipeline stage that reads them, so order between loads and renders holds.
// reset clears the pipeline and loads register defaults; memory contents are
// not cleared and an entry must be loaded before a render reads it.
// when rsp is stalled the result holds; the pipeline keeps taking words until
// a finished result waits behind the held one, then req.ready drops.
module lens_table_texture_gather #(
   parameter int TABLE_WIDTH  = 320,
   parameter int TABLE_HEIGHT = 240,
   parameter int PANO_WIDTH   = 512,
   parameter int PANO_HEIGHT  = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   ltg_req_if.sink                         req,
   ltg_rsp_if.source                       rsp,
   input  logic                            csr_write_enable,
   input  logic [ltg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ltg_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import ltg_pkg::*;

   localparam int TAB_SIZE  = TABLE_WIDTH * TABLE_HEIGHT;
   localparam int TAB_AW    = $clog2(TAB_SIZE);
   localparam int TX_W      = $clog2(TABLE_WIDTH);
   localparam int TY_W      = $clog2(TABLE_HEIGHT);
   localparam int PANO_SIZE = PANO_WIDTH * PANO_HEIGHT;
   localparam int PANO_AW   = $clog2(PANO_SIZE);
   localparam int PU_W      = $clog2(PANO_WIDTH);
   localparam int STAGES    = 7;
   localparam logic signed [SUM_W-1:0] SX_BASE = SUM_W'(TABLE_WIDTH * (1 << 14));
   localparam logic signed [SUM_W-1:0] SY_BASE = SUM_W'(TABLE_HEIGHT * (1 << 14));
   localparam logic signed [SUM_W-1:0] RND     = SUM_W'((1 << FRAC_BITS) - 1);

   function automatic logic [TX_W-1:0] clamp_x(input logic signed [LOC_W-1:0] v);
      logic [TX_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v >= $signed(LOC_W'(TABLE_WIDTH))) begin
         r = TX_W'(TABLE_WIDTH - 1);
      end else begin
         r = v[TX_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [TY_W-1:0] clamp_y(input logic signed [LOC_W-1:0] v);
      logic [TY_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v >= $signed(LOC_W'(TABLE_HEIGHT))) begin
         r = TY_W'(TABLE_HEIGHT - 1);
      end else begin
         r = v[TY_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [TAB_AW-1:0] tab_index(input logic [TY_W-1:0] y,
                                                  input logic [TX_W-1:0] x);
      return TAB_AW'(32'(y) * TABLE_WIDTH + 32'(x));
   endfunction

   // configuration registers
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   logic [YAW_W-1:0]         yaw_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic [VALUE_W-1:0]       shadow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= TRIG_W'(16384);
         sin_ff    <= '0;
         yaw_ff    <= '0;
         gain_ff   <= GAIN_W'(256);
         shadow_ff <= '1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROT_COS: cos_ff    <= csr_write_data[TRIG_W-1:0];
            CSR_ROT_SIN: sin_ff    <= csr_write_data[TRIG_W-1:0];
            CSR_YAW:     yaw_ff    <= csr_write_data[YAW_W-1:0];
            CSR_GAIN:    gain_ff   <= csr_write_data[GAIN_W-1:0];
            CSR_SHADOW:  shadow_ff <= csr_write_data[VALUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   logic          adv;
   item_type      item_in;
   item_type      item_ff [1:STAGES];
   shade_ctl_type shade_ctl_out;
   logic          rsp_valid_ff;

   assign adv = !shade_ctl_out.valid || !rsp_valid_ff || rsp.ready;
   assign req.ready = adv;

   assign item_in.valid = req.valid && adv;
   assign item_in.kind  = req.kind;
   assign item_in.addr  = req.load_address;
   assign item_in.value = req.load_value;
   assign item_in.x     = req.pixel_x;
   assign item_in.y     = req.pixel_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= STAGES; k++) begin
            item_ff[k] <= '0;
         end
      end else if (adv) begin
         item_ff[1] <= item_in;
         for (int k = 2; k <= STAGES; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   // stage 1: offsets from the screen center
   logic signed [DELTA_W-1:0] dx2_in, dy2_in, dx2_ff, dy2_ff;

   assign dx2_in = $signed({{(DELTA_W-X_W-1){1'b0}}, req.pixel_x, 1'b0})
                 - $signed(DELTA_W'(TABLE_WIDTH));
   assign dy2_in = $signed({{(DELTA_W-Y_W-1){1'b0}}, req.pixel_y, 1'b0})
                 - $signed(DELTA_W'(TABLE_HEIGHT));

   // stage 2: rotation products
   logic signed [PROD_W-1:0] pcx_in, psy_in, psx_in, pcy_in;
   logic signed [PROD_W-1:0] pcx_ff, psy_ff, psx_ff, pcy_ff;

   assign pcx_in = dx2_ff * cos_ff;
   assign psy_in = dy2_ff * sin_ff;
   assign psx_in = dx2_ff * sin_ff;
   assign pcy_in = dy2_ff * cos_ff;

   // stage 3: table location, truncated toward zero
   logic signed [SUM_W-1:0] sx_in, sy_in, sx_adj, sy_adj;
   logic signed [LOC_W-1:0] lx_in, ly_in, lx_ff, ly_ff;
   logic                    inr_in, inr3_ff, inr4_ff, inr5_ff;

   assign sx_in  = SX_BASE + pcx_ff - psy_ff;
   assign sy_in  = SY_BASE + psx_ff + pcy_ff;
   assign sx_adj = sx_in + (sx_in[SUM_W-1] ? RND : SUM_W'(0));
   assign sy_adj = sy_in + (sy_in[SUM_W-1] ? RND : SUM_W'(0));
   assign lx_in  = LOC_W'(sx_adj >>> FRAC_BITS);
   assign ly_in  = LOC_W'(sy_adj >>> FRAC_BITS);
   assign inr_in = !lx_in[LOC_W-1] && (lx_in < $signed(LOC_W'(TABLE_WIDTH)))
                && !ly_in[LOC_W-1] && (ly_in < $signed(LOC_W'(TABLE_HEIGHT)));

   // stage 4: center and neighbor addresses, clamped to the table edge
   logic [TAB_AW-1:0] idx_c_ff, idx_l_ff, idx_r_ff, idx_u_ff, idx_d_ff;
   logic [TX_W-1:0]   cx_in, cxm_in, cxp_in;
   logic [TY_W-1:0]   cy_in, cym_in, cyp_in;

   assign cx_in  = clamp_x(lx_ff);
   assign cxm_in = clamp_x(lx_ff - LOC_W'(2));
   assign cxp_in = clamp_x(lx_ff + LOC_W'(2));
   assign cy_in  = clamp_y(ly_ff);
   assign cym_in = clamp_y(ly_ff - LOC_W'(2));
   assign cyp_in = clamp_y(ly_ff + LOC_W'(2));

   always_ff @(posedge clock) begin
      if (adv) begin
         dx2_ff   <= dx2_in;
         dy2_ff   <= dy2_in;
         pcx_ff   <= pcx_in;
         psy_ff   <= psy_in;
         psx_ff   <= psx_in;
         pcy_ff   <= pcy_in;
         lx_ff    <= lx_in;
         ly_ff    <= ly_in;
         inr3_ff  <= inr_in;
         idx_c_ff <= tab_index(cy_in, cx_in);
         idx_l_ff <= tab_index(cy_in, cxm_in);
         idx_r_ff <= tab_index(cy_in, cxp_in);
         idx_u_ff <= tab_index(cym_in, cx_in);
         idx_d_ff <= tab_index(cyp_in, cx_in);
         inr4_ff  <= inr3_ff;
         inr5_ff  <= inr4_ff;
      end
   end

   // lens table copies, written by lens loads in stage 4
   logic [VALUE_W-1:0] lens_mem_a [TAB_SIZE];
   logic [VALUE_W-1:0] lens_mem_b [TAB_SIZE];
   logic [VALUE_W-1:0] lens_mem_c [TAB_SIZE];
   logic [VALUE_W-1:0] lens_c_rd_ff, lens_l_rd_ff, lens_r_rd_ff;
   logic [VALUE_W-1:0] lens_u_rd_ff, lens_d_rd_ff;
   logic               lens_we;
   logic [TAB_AW-1:0]  lens_wa;

   assign lens_we = adv && item_ff[4].valid && (item_ff[4].kind == KIND_LENS)
                 && (32'(item_ff[4].addr) < TAB_SIZE);
   assign lens_wa = TAB_AW'(item_ff[4].addr);

   always_ff @(posedge clock) begin
      if (lens_we) begin
         lens_mem_a[lens_wa] <= item_ff[4].value;
      end
      if (adv) begin
         lens_c_rd_ff <= lens_mem_a[idx_c_ff];
         lens_l_rd_ff <= lens_mem_a[idx_l_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (lens_we) begin
         lens_mem_b[lens_wa] <= item_ff[4].value;
      end
      if (adv) begin
         lens_r_rd_ff <= lens_mem_b[idx_r_ff];
         lens_u_rd_ff <= lens_mem_b[idx_u_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (lens_we) begin
         lens_mem_c[lens_wa] <= item_ff[4].value;
      end
      if (adv) begin
         lens_d_rd_ff <= lens_mem_c[idx_d_ff];
      end
   end

   // stage 5: panorama addresses, fraction, shadow tests
   logic [17:0]        pos_in;
   logic [9:0]         urem;
   logic [PU_W-1:0]    ui_in, u1_in;
   logic [6:0]         vsat_in;
   logic [2:0]         near_in;
   logic               black_in;
   logic [PANO_AW-1:0] pa0_ff, pa1_ff;
   logic [7:0]         fr6_ff, fr7_ff;
   logic [2:0]         near6_ff, near7_ff;
   logic               black6_ff, black7_ff;

   assign pos_in = {1'b0, lens_c_rd_ff[VALUE_W-1:U_LSB], 8'd0} + {1'b0, yaw_ff};

   always_comb begin
      urem = pos_in[17:8];
      for (int k = 6; k >= 0; k--) begin
         if (32'(urem) >= (PANO_WIDTH << k)) begin
            urem = urem - 10'(PANO_WIDTH << k);
         end
      end
   end

   assign ui_in   = PU_W'(urem);
   assign u1_in   = (32'(ui_in) == PANO_WIDTH - 1) ? '0 : ui_in + 1'b1;
   assign vsat_in = (32'(lens_c_rd_ff[U_LSB-1:0]) >= PANO_HEIGHT) ?
                    7'(PANO_HEIGHT - 1) : lens_c_rd_ff[U_LSB-1:0];
   assign near_in = 3'(lens_l_rd_ff == shadow_ff) + 3'(lens_r_rd_ff == shadow_ff)
                  + 3'(lens_u_rd_ff == shadow_ff) + 3'(lens_d_rd_ff == shadow_ff);
   assign black_in = !inr5_ff || (lens_c_rd_ff == shadow_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         pa0_ff    <= PANO_AW'(32'(vsat_in) * PANO_WIDTH + 32'(ui_in));
         pa1_ff    <= PANO_AW'(32'(vsat_in) * PANO_WIDTH + 32'(u1_in));
         fr6_ff    <= pos_in[7:0];
         near6_ff  <= near_in;
         black6_ff <= black_in;
         fr7_ff    <= fr6_ff;
         near7_ff  <= near6_ff;
         black7_ff <= black6_ff;
      end
   end

   // panorama, written by texel loads in stage 6
   logic [VALUE_W-1:0] pano_mem [PANO_SIZE];
   logic [VALUE_W-1:0] pc0_rd_ff, pc1_rd_ff;
   logic               pano_we;

   assign pano_we = adv && item_ff[6].valid && (item_ff[6].kind == KIND_TEXEL)
                 && (32'(item_ff[6].addr) < PANO_SIZE);

   always_ff @(posedge clock) begin
      if (pano_we) begin
         pano_mem[PANO_AW'(item_ff[6].addr)] <= item_ff[6].value;
      end
      if (adv) begin
         pc0_rd_ff <= pano_mem[pa0_ff];
         pc1_rd_ff <= pano_mem[pa1_ff];
      end
   end

   // stages 8 and 9: blend, glow, gain
   shade_ctl_type       shade_ctl_in;
   logic [SCALED_W-1:0] red_sc, green_sc, blue_sc;

   assign shade_ctl_in.valid = item_ff[7].valid && (item_ff[7].kind == KIND_RENDER);
   assign shade_ctl_in.black = black7_ff;
   assign shade_ctl_in.near  = near7_ff;
   assign shade_ctl_in.x     = item_ff[7].x;
   assign shade_ctl_in.y     = item_ff[7].y;

   ltg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .ctl_in    (shade_ctl_in),
      .c0        (pc0_rd_ff),
      .c1        (pc1_rd_ff),
      .fr        (fr7_ff),
      .gain      (gain_ff),
      .ctl_out   (shade_ctl_out),
      .red_out   (red_sc),
      .green_out (green_sc),
      .blue_out  (blue_sc)
   );

   // output register
   function automatic logic [CH_W-1:0] sat8(input logic [SCALED_W-1:0] v);
      logic [SCALED_W-1:0] s;
      s = v >> GAIN_SHIFT;
      return (s > SCALED_W'(CH_MAX)) ? CH_W'(CH_MAX) : s[CH_W-1:0];
   endfunction

   logic [CH_W-1:0]    r8_in, g8_in, b8_in;
   logic [COLOR_W-1:0] color_in, color_ff;
   logic [X_W-1:0]     ox_ff;
   logic [Y_W-1:0]     oy_ff;

   assign r8_in    = sat8(red_sc);
   assign g8_in    = sat8(green_sc);
   assign b8_in    = sat8(blue_sc);
   assign color_in = shade_ctl_out.black ? '0 : {r8_in[7:3], g8_in[7:2], b8_in[7:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && shade_ctl_out.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && shade_ctl_out.valid) begin
         color_ff <= color_in;
         ox_ff    <= shade_ctl_out.x;
         oy_ff    <= shade_ctl_out.y;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_color = color_ff;
   assign rsp.out_x       = ox_ff;
   assign rsp.out_y       = oy_ff;

   // a new result only comes from a render that left the shading stages
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(shade_ctl_out.valid))
      else $error("result appeared without a finished render");

   // a stall freezes the pipeline in front of the memories
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(item_ff[STAGES]) && $stable(pc0_rd_ff) && $stable(pc1_rd_ff))
      else $error("pipeline moved during a stall");

   // the block only blocks input when a result waits behind a held one
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp_valid_ff && shade_ctl_out.valid)
      else $error("input blocked without a waiting result");

endmodule
